// File: rtl/core/rrs_pkg.sv
// Shared types, sizes and helpers for the round-robin scheduler.
// No dependencies; every other file in rtl/core except rrs_ram refers to this package.
package rrs_pkg;

  // Sizes
  localparam int QueueDepth   = 16;
  localparam int TimeWidth    = 16;
  localparam int IdWidth      = 8;
  localparam int NeedWidth    = 16;   // width of the need_time field
  localparam int ServedWidth  = 16;   // width of served_used / served_left
  localparam int QuantumWidth = 8;
  localparam int SliceWidth   = 8;
  localparam int PtrWidth     = $clog2(QueueDepth);
  localparam int CountWidth   = $clog2(QueueDepth + 1);
  localparam int EntryWidth   = IdWidth + 2 * TimeWidth;
  localparam int InDataWidth  = 24;
  localparam int OutDataWidth = 48;

  localparam logic [QuantumWidth-1:0] QuantumReset = QuantumWidth'(2);

  typedef logic [PtrWidth-1:0]   ptr_t;
  typedef logic [CountWidth-1:0] count_t;
  typedef logic [TimeWidth-1:0]  time_t;
  typedef logic [IdWidth-1:0]    id_t;

  // Result status codes
  typedef enum logic [2:0] {
    STATUS_ADDED     = 3'd0,
    STATUS_FULL      = 3'd1,
    STATUS_ZERO_TIME = 3'd2,
    STATUS_IDLE      = 3'd3,
    STATUS_RAN       = 3'd4,
    STATUS_PREEMPTED = 3'd5,
    STATUS_FINISHED  = 3'd6
  } status_e;

  // Controller states, one-hot
  typedef enum logic [1:0] {
    CTRL_IDLE = 2'b01,
    CTRL_EXEC = 2'b10
  } ctrl_state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic    latch;      // register the item and read the queue head
    logic    exec;       // update state and load the result register
    logic    push_new;   // append the added process to the queue
    logic    dispatch;   // take the queue head as the running process
    logic    serve;      // run one time unit
    status_e add_status; // result code when no time unit is served
  } ctrl_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic tick;
    logic need_zero;
    logic queue_full;
    logic queue_empty;
    logic run_valid;
  } dp_status_t;

  // Ring pointer advance
  function automatic ptr_t ptr_inc(ptr_t p);
    ptr_t r;
    if (p == PtrWidth'(QueueDepth - 1)) begin
      r = '0;
    end else begin
      r = p + 1'b1;
    end
    return r;
  endfunction

endpackage

// File: rtl/core/rrs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rrs_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/rrs_ctrl.sv
// Scheduler controller: two-state sequencer, output valid and item decode.
// Depends on rrs_pkg.
module rrs_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  rrs_pkg::dp_status_t status_i,
  output rrs_pkg::ctrl_cmd_t  cmd_o
);

  rrs_pkg::ctrl_state_e state_q, state_d;
  logic out_valid_q, out_valid_d;

  // Take an item only when the result register is free by the next cycle
  assign in_ready_o = (state_q == rrs_pkg::CTRL_IDLE) && (!out_valid_q || out_ready_i);

  // Next state and command decode
  always_comb begin
    state_d            = state_q;
    cmd_o              = '0;
    cmd_o.add_status   = rrs_pkg::STATUS_ADDED;
    unique case (state_q)
      rrs_pkg::CTRL_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          cmd_o.latch = 1'b1;
          state_d     = rrs_pkg::CTRL_EXEC;
        end
      end
      rrs_pkg::CTRL_EXEC: begin
        cmd_o.exec = 1'b1;
        if (!status_i.tick) begin
          if (status_i.need_zero) begin
            cmd_o.add_status = rrs_pkg::STATUS_ZERO_TIME;
          end else if (status_i.queue_full) begin
            cmd_o.add_status = rrs_pkg::STATUS_FULL;
          end else begin
            cmd_o.push_new   = 1'b1;
            cmd_o.add_status = rrs_pkg::STATUS_ADDED;
          end
        end else if (status_i.run_valid) begin
          cmd_o.serve = 1'b1;
        end else if (status_i.queue_empty) begin
          cmd_o.add_status = rrs_pkg::STATUS_IDLE;
        end else begin
          cmd_o.dispatch = 1'b1;
          cmd_o.serve    = 1'b1;
        end
        state_d = rrs_pkg::CTRL_IDLE;
      end
      default: begin
        state_d = rrs_pkg::CTRL_IDLE;
      end
    endcase
  end

  // Result valid flag
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.exec) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rrs_pkg::CTRL_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// File: rtl/core/rrs_datapath.sv
// Scheduler datapath: ready-queue RAM and pointers, running process, result register.
// Depends on rrs_pkg and rrs_ram.
module rrs_datapath (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  rrs_pkg::ctrl_cmd_t                   cmd_i,
  output rrs_pkg::dp_status_t                  status_o,
  input  logic                                 in_tick_i,
  input  logic [rrs_pkg::InDataWidth-1:0]      in_data_i,
  input  logic                                 cfg_we_i,
  input  logic [rrs_pkg::QuantumWidth-1:0]     cfg_wdata_i,
  output logic [rrs_pkg::OutDataWidth-1:0]     out_data_o,
  output logic [2:0]                           out_user_o
);

  // Latched item
  logic                 tick_q;
  rrs_pkg::id_t         pid_q;
  rrs_pkg::time_t       need_q;

  // Configuration
  logic [rrs_pkg::QuantumWidth-1:0] quantum_q;

  // Queue control
  rrs_pkg::ptr_t   head_q, head_d, tail_q, tail_d;
  rrs_pkg::count_t fill_q, fill_d, fill_deq;

  // Running process
  logic                           run_valid_q;
  rrs_pkg::id_t                   run_id_q;
  rrs_pkg::time_t                 run_left_q, run_used_q;
  logic [rrs_pkg::SliceWidth-1:0] slice_q;

  // RAM ports
  logic                             ram_we;
  logic [rrs_pkg::EntryWidth-1:0]   ram_wdata, ram_rdata;

  // Serve path
  rrs_pkg::id_t                     cur_id;
  rrs_pkg::time_t                   cur_left, cur_used, new_left, new_used;
  logic [rrs_pkg::SliceWidth-1:0]   cur_slice, new_slice, slice_next;
  logic [rrs_pkg::QuantumWidth-1:0] quantum_eff;
  logic                             requeue, keep_running;
  rrs_pkg::status_e                 serve_status, out_status;
  logic [rrs_pkg::OutDataWidth-1:0] out_data_d;

  logic [rrs_pkg::OutDataWidth-1:0] out_data_q;
  logic [2:0]                       out_user_q;

  rrs_ram #(
    .Width(rrs_pkg::EntryWidth),
    .Depth(rrs_pkg::QueueDepth)
  ) u_queue_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(tail_q),
    .wdata_i(ram_wdata),
    .re_i   (cmd_i.latch),
    .raddr_i(head_q),
    .rdata_o(ram_rdata)
  );

  // Status to controller
  assign status_o.tick        = tick_q;
  assign status_o.need_zero   = (need_q == '0);
  assign status_o.queue_full  = (fill_q == rrs_pkg::CountWidth'(rrs_pkg::QueueDepth));
  assign status_o.queue_empty = (fill_q == '0);
  assign status_o.run_valid   = run_valid_q;

  // One time unit for the running or freshly dispatched process
  always_comb begin
    cur_id      = run_id_q;
    cur_left    = run_left_q;
    cur_used    = run_used_q;
    cur_slice   = slice_q;
    if (cmd_i.dispatch) begin
      cur_id    = ram_rdata[rrs_pkg::IdWidth-1:0];
      cur_left  = ram_rdata[rrs_pkg::IdWidth +: rrs_pkg::TimeWidth];
      cur_used  = ram_rdata[rrs_pkg::IdWidth + rrs_pkg::TimeWidth +: rrs_pkg::TimeWidth];
      cur_slice = '0;
    end
    new_slice   = cur_slice + rrs_pkg::SliceWidth'(1);
    new_used    = cur_used + rrs_pkg::TimeWidth'(1);
    new_left    = cur_left - rrs_pkg::TimeWidth'(1);
    fill_deq    = fill_q - rrs_pkg::CountWidth'(cmd_i.dispatch);
    quantum_eff = (quantum_q == '0) ? rrs_pkg::QuantumWidth'(1) : quantum_q;

    requeue      = 1'b0;
    keep_running = 1'b1;
    slice_next   = new_slice;
    serve_status = rrs_pkg::STATUS_RAN;
    if (new_left == '0) begin
      serve_status = rrs_pkg::STATUS_FINISHED;
      keep_running = 1'b0;
      slice_next   = '0;
    end else if (new_slice >= quantum_eff) begin
      slice_next = '0;
      if (fill_deq != rrs_pkg::CountWidth'(rrs_pkg::QueueDepth)) begin
        requeue      = 1'b1;
        keep_running = 1'b0;
        serve_status = rrs_pkg::STATUS_PREEMPTED;
      end
    end
  end

  // Queue write and pointer update
  always_comb begin
    ram_we    = cmd_i.push_new || (cmd_i.serve && requeue);
    ram_wdata = cmd_i.push_new ? {rrs_pkg::TimeWidth'(0), need_q, pid_q}
                               : {new_used, new_left, cur_id};
    head_d    = cmd_i.dispatch ? rrs_pkg::ptr_inc(head_q) : head_q;
    tail_d    = ram_we ? rrs_pkg::ptr_inc(tail_q) : tail_q;
    fill_d    = fill_deq + rrs_pkg::CountWidth'(ram_we);
  end

  // Result word: id, used, left, ready count from the low bit up
  always_comb begin
    out_data_d = '0;
    out_data_d[40 +: rrs_pkg::CountWidth] = fill_d;
    out_status = cmd_i.add_status;
    if (cmd_i.serve) begin
      out_status                 = serve_status;
      out_data_d[7:0]            = cur_id;
      out_data_d[23:8]           = rrs_pkg::ServedWidth'(new_used);
      out_data_d[39:24]          = rrs_pkg::ServedWidth'(new_left);
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quantum_q   <= rrs_pkg::QuantumReset;
      head_q      <= '0;
      tail_q      <= '0;
      fill_q      <= '0;
      run_valid_q <= 1'b0;
      run_id_q    <= '0;
      run_left_q  <= '0;
      run_used_q  <= '0;
      slice_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        quantum_q <= cfg_wdata_i;
      end
      if (cmd_i.exec) begin
        head_q <= head_d;
        tail_q <= tail_d;
        fill_q <= fill_d;
      end
      if (cmd_i.serve) begin
        run_valid_q <= keep_running;
        run_id_q    <= cur_id;
        run_left_q  <= new_left;
        run_used_q  <= new_used;
        slice_q     <= slice_next;
      end
    end
  end

  // Item and result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      tick_q <= in_tick_i;
      pid_q  <= in_data_i[rrs_pkg::IdWidth-1:0];
      need_q <= in_data_i[rrs_pkg::IdWidth +: rrs_pkg::TimeWidth];
    end
    if (cmd_i.exec) begin
      out_data_q <= out_data_d;
      out_user_q <= out_status;
    end
  end

  assign out_data_o = out_data_q;
  assign out_user_o = out_user_q;

endmodule

// File: rtl/core/round_robin_scheduler.sv
// Round-robin time-slice scheduler, top level.
// Depends on rrs_pkg, rrs_ctrl, rrs_datapath (and through it rrs_ram).
//
// Each item passes an accept cycle, which registers it and reads the head entry of
// the ready-queue RAM, and the next cycle, which updates queue and running process
// and loads the result register; no new item is accepted before that is done. The
// single-read queue RAM with registered read data sets that split. The next item is
// accepted while a result is being taken. Quantum changes take effect on the
// following tick; quantum zero acts as one.
module round_robin_scheduler (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Item in
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [rrs_pkg::InDataWidth-1:0]     s_axis_tdata,  // process_id, need_time
  input  logic                                s_axis_tuser,  // command
  // Result out
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [rrs_pkg::OutDataWidth-1:0]    m_axis_tdata,  // served_id, served_used,
                                                             // served_left, ready_count
  output logic [2:0]                          m_axis_tuser,  // status
  // Quantum register
  input  logic                                cfg_we_i,
  input  logic [rrs_pkg::QuantumWidth-1:0]    cfg_wdata_i
);

  rrs_pkg::ctrl_cmd_t  cmd;
  rrs_pkg::dp_status_t status;

  rrs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  rrs_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .status_o   (status),
    .in_tick_i  (s_axis_tuser),
    .in_data_i  (s_axis_tdata),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .out_data_o (m_axis_tdata),
    .out_user_o (m_axis_tuser)
  );

endmodule

// File: rtl/core/rrs_checker.sv
// Port-level checks for the round-robin scheduler, bound to the top level.
// Depends on rrs_pkg and round_robin_scheduler.
module rrs_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [rrs_pkg::OutDataWidth-1:0] m_axis_tdata,
  input logic [2:0]                       m_axis_tuser
);

  // Stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // One item in flight: no accept right after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("item accepted while previous still in work");

  // Every accepted item raises the result valid flag once its result is loaded
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |-> ##2 m_axis_tvalid)
    else $error("result missing after item");

  // Ready count never exceeds the queue depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[44:40] <= 5'(rrs_pkg::QueueDepth))
    else $error("ready count beyond queue depth");

  // Results without a served process carry zero served fields
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == rrs_pkg::STATUS_ADDED
      || m_axis_tuser == rrs_pkg::STATUS_FULL
      || m_axis_tuser == rrs_pkg::STATUS_ZERO_TIME
      || m_axis_tuser == rrs_pkg::STATUS_IDLE) |-> m_axis_tdata[39:0] == '0)
    else $error("served fields set on a non-serving result");

endmodule

bind round_robin_scheduler rrs_checker u_rrs_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser)
);

// File: sim/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for round_robin_scheduler: predicts every result item
// with its own scheduler model and checks the results under random idling on both stream sides.
// Depends on rrs_pkg and the scheduler RTL only.
module testbench;
  import rrs_pkg::*;

  localparam logic CmdAdd  = 1'b0;
  localparam logic CmdTick = 1'b1;
  localparam int   HoldCycles = 400;
  localparam int   CycleLimit = 200000;
  localparam int   DrainCycles = 20;

  // One ready-queue entry or the running process
  typedef struct packed {
    id_t   id;
    time_t left;
    time_t used;
  } proc_t;

  // One result item as the block should report it
  typedef struct packed {
    status_e status;
    id_t     id;
    time_t   used;
    time_t   left;
    count_t  ready;
  } outcome_t;

  // Scheduler predictor plus the outcomes still to be seen
  class sched_scoreboard;
    logic [QuantumWidth-1:0] quantum;
    proc_t                   ready_q[$];
    bit                      run_valid;
    proc_t                   running;
    logic [SliceWidth-1:0]   slice;
    outcome_t                awaited[$];
    int                      errors;
    int                      items;
    int                      seen[8];

    function new();
      quantum   = QuantumReset;
      run_valid = 1'b0;
      running   = '0;
      slice     = '0;
      errors    = 0;
      items     = 0;
      foreach (seen[i]) seen[i] = 0;
    endfunction

    function int fill();
      return ready_q.size();
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    // Advance the model by one accepted item and queue its outcome
    function void accept_item(logic cmd, id_t pid, time_t need);
      outcome_t r;
      proc_t    e;
      int       q;
      r = '0;
      items++;
      if (cmd == CmdAdd) begin
        if (need == '0) begin
          r.status = STATUS_ZERO_TIME;
        end else if (ready_q.size() >= QueueDepth) begin
          r.status = STATUS_FULL;
        end else begin
          e.id   = pid;
          e.left = need;
          e.used = '0;
          ready_q.push_back(e);
          r.status = STATUS_ADDED;
        end
      end else if (!run_valid && ready_q.size() == 0) begin
        r.status = STATUS_IDLE;
      end else begin
        if (!run_valid) begin
          running   = ready_q.pop_front();
          run_valid = 1'b1;
          slice     = '0;
        end
        slice        = slice + 1'b1;
        running.used = running.used + 1'b1;
        running.left = running.left - 1'b1;
        q = (quantum == 0) ? 1 : int'(quantum);
        r.status = STATUS_RAN;
        if (running.left == '0) begin
          r.status  = STATUS_FINISHED;
          run_valid = 1'b0;
          slice     = '0;
        end else if (int'(slice) >= q) begin
          slice = '0;
          // a full queue leaves the process running
          if (ready_q.size() < QueueDepth) begin
            ready_q.push_back(running);
            run_valid = 1'b0;
            r.status  = STATUS_PREEMPTED;
          end
        end
        r.id   = running.id;
        r.used = running.used;
        r.left = running.left;
      end
      r.ready = count_t'(ready_q.size());
      awaited.push_back(r);
    endfunction

    function void compare_field(string field, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, field, want, got);
      end
    endfunction

    // Compare one result item with the oldest outcome
    function void check_result(logic [2:0] status, logic [OutDataWidth-1:0] data);
      outcome_t w;
      if (awaited.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none actual status %0h data %0h",
                 $time, status, data);
        return;
      end
      w = awaited.pop_front();
      seen[w.status]++;
      compare_field("status", 16'(w.status), 16'(status));
      compare_field("served_id", 16'(w.id), 16'(data[7:0]));
      compare_field("served_used", w.used, data[23:8]);
      compare_field("served_left", w.left, data[39:24]);
      compare_field("ready_count", 16'(w.ready), 16'(data[44:40]));
      compare_field("padding", 16'h0, 16'(data[47:45]));
    endfunction
  endclass

  logic                    clk_i;
  logic                    rst_ni;
  logic                    s_axis_tvalid;
  logic                    s_axis_tready;
  logic [InDataWidth-1:0]  s_axis_tdata;
  logic                    s_axis_tuser;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready;
  logic [OutDataWidth-1:0] m_axis_tdata;
  logic [2:0]              m_axis_tuser;
  logic                    cfg_we_i;
  logic [QuantumWidth-1:0] cfg_wdata_i;

  sched_scoreboard sb;
  int src_idle_pct;
  int sink_idle_pct;
  int hold_requests;
  int hold_seen;
  int hold_left;
  int cycle_count;

  round_robin_scheduler DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Run limit
  initial cycle_count = 0;
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Result side: random stalls, plus one long hold-off on request
  initial begin
    hold_seen = 0;
    hold_left = 0;
  end
  always @(negedge clk_i) begin
    if (hold_seen != hold_requests) begin
      hold_seen = hold_requests;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      sb.check_result(m_axis_tuser, m_axis_tdata);
    end
  end

  // Offer one item, starting and ending at a falling edge
  task automatic send_item(logic cmd, id_t pid, time_t need);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {need, pid};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.accept_item(cmd, pid, need);
    @(negedge clk_i);
  endtask

  task automatic add_proc(id_t pid, time_t need);
    send_item(CmdAdd, pid, need);
  endtask

  // Tick items carry random, ignored payload
  task automatic tick();
    send_item(CmdTick, id_t'($urandom_range(255)), time_t'($urandom_range(65535)));
  endtask

  // Stop offering and wait until every outcome is in; ends at a rising edge
  task automatic quiesce();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  // Quantum write while the block is idle; ends at a falling edge
  task automatic write_quantum(logic [QuantumWidth-1:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.quantum = value;
  endtask

  // Random mix: mostly short jobs so that they finish and cycle through the queue
  task automatic random_item(int tick_pct);
    int    roll;
    time_t need;
    if ($urandom_range(99) < tick_pct) begin
      tick();
    end else begin
      roll = $urandom_range(199);
      if (sb.fill() >= QueueDepth || roll == 0) begin
        need = time_t'($urandom_range(65535));
      end else if (roll < 12) begin
        need = '0;
      end else begin
        need = time_t'($urandom_range(1, 12));
      end
      add_proc(id_t'($urandom_range(255)), need);
    end
  endtask

  task automatic random_phase(int src_pct, int sink_pct, logic [QuantumWidth-1:0] q,
                              int count, int tick_pct, bit with_hold);
    quiesce();
    src_idle_pct  = src_pct;
    sink_idle_pct = sink_pct;
    if (with_hold) hold_requests++;
    write_quantum(q);
    repeat (count) random_item(tick_pct);
  endtask

  initial begin
    sb = new();
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = CmdAdd;
    m_axis_tready = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    src_idle_pct  = 21;
    sink_idle_pct = 78;
    hold_requests = 0;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: idle tick, zero time, extreme fields, preemption at reset quantum
    tick();
    add_proc(8'h00, 16'h0000);
    add_proc(8'hFF, 16'hFFFF);
    tick();
    tick();
    tick();
    // Widest quantum, then lowered mid-slice so the next tick preempts
    quiesce();
    write_quantum(8'd255);
    tick();
    tick();
    quiesce();
    write_quantum(8'd1);
    tick();
    // Quantum zero behaves as one
    quiesce();
    write_quantum(8'd0);
    tick();
    quiesce();
    write_quantum(8'd2);
    // Fill the queue behind a running process, overflow it, then reach the quantum on full so no preemption happens
    tick();
    for (int i = 0; i < QueueDepth; i++) begin
      add_proc(id_t'(i * 17), 16'd3);
    end
    add_proc(8'hA5, 16'h5A5A);
    tick();

    // Random phases with changing idling and quantum; long result hold-off in the last
    random_phase(21, 78, 8'd1, 350, 55, 1'b0);
    random_phase(78, 21, 8'($urandom_range(2, 6)), 350, 85, 1'b0);
    random_phase(0, 0, 8'($urandom_range(3, 8)), 350, 65, 1'b1);

    quiesce();
    repeat (DrainCycles) @(posedge clk_i);
    $display("Items: %0d sent, quantum 0, 1, 2, 255 and random; outcomes added %0d full %0d",
             sb.items, sb.seen[STATUS_ADDED], sb.seen[STATUS_FULL]);
    $display("zero-time %0d idle %0d ran %0d preempted %0d finished %0d",
             sb.seen[STATUS_ZERO_TIME], sb.seen[STATUS_IDLE], sb.seen[STATUS_RAN],
             sb.seen[STATUS_PREEMPTED], sb.seen[STATUS_FINISHED]);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
